>>> rtl/ctbl_pkg.sv
// shared types and constants of the cursor text buffer
package ctbl_pkg;

  // field widths
  localparam int REQ_W  = 3;
  localparam int CHAR_W = 8;
  localparam int ST_W   = 3;
  localparam int LINK_W = 7;

  // link value that points nowhere
  localparam logic [LINK_W-1:0] LINK_NULL = 7'h7F;

  // request codes
  localparam logic [REQ_W-1:0] REQ_LEFT   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_RIGHT  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_BACK   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd3;
  localparam logic [REQ_W-1:0] REQ_LIST   = 3'd4;

  // result status codes
  localparam logic [ST_W-1:0] ST_DONE  = 3'd0;
  localparam logic [ST_W-1:0] ST_EDGE  = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 3'd2;
  localparam logic [ST_W-1:0] ST_CHAR  = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY = 3'd4;

  // node store strobes from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_char;
    logic wr_prev;
    logic wr_next;
  } node_ctl_t;

endpackage

>>> rtl/ctbl_req_if.sv
// request channel: valid/ready with request type and character
interface ctbl_req_if;
  import ctbl_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [CHAR_W-1:0] char_in;

  modport source (output valid, output req_type, output char_in, input ready);
  modport sink   (input valid, input req_type, input char_in, output ready);
endinterface

>>> rtl/ctbl_rsp_if.sv
// result channel: valid/ready with status, character and last flag
interface ctbl_rsp_if;
  import ctbl_pkg::*;

  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [CHAR_W-1:0] char_out;
  logic              last;

  modport source (output valid, output status, output char_out, output last, input ready);
  modport sink   (input valid, input status, input char_out, input last, output ready);
endinterface

>>> rtl/cursor_text_buffer_linked_list_core.sv
// top level: request sequencer of the linked list text buffer
// Line-editing text buffer held as a doubly linked list of NODES nodes,
// node 0 being the head. Requests arrive on the req channel (valid/ready,
// a beat is taken when both are high); results leave on the rsp channel.
// Cursor moves, backspace and insert give one result with last set;
// a listing gives one beat per character, last on the final one, or one
// empty-status beat when the buffer holds nothing.
// Sequencing: a request is taken in S_IDLE, which reads its links from the
// node store; they come back in the next state, S_EDIT. Moves, backspace,
// full inserts and unknown codes then post their result from S_REPLY,
// subject to output wait. A successful insert passes through S_LINK first
// for its second pair of link writes (single write port per link memory).
// Listing reads one character at a time in S_LIST, bound by the node
// store read port.
// req.ready is high only while the sequencer is idle; one result register
// sits on the output, so a stalled receiver holds the sequencer at its
// next beat but never loses one. Reset empties the buffer, puts the
// cursor on the head node and restarts node allocation at node 1;
// freed nodes are not reused, so at most NODES-1 inserts succeed.
module cursor_text_buffer_linked_list_core #(
  parameter int NODES = 64
) (
  input  logic         clk,
  input  logic         rst,
  ctbl_req_if.sink     req,
  ctbl_rsp_if.source   rsp
);
  import ctbl_pkg::*;

  localparam int AW = $clog2(NODES);
  localparam int CW = $clog2(NODES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDIT,
    S_LINK,
    S_LIST,
    S_REPLY
  } state_t;

  state_t            state, state_next;
  logic [AW-1:0]     cursor, cursor_next;
  logic [LINK_W-1:0] free_node, free_node_next;
  logic [ST_W-1:0]   st_hold, st_hold_next;
  logic [CW-1:0]     count, count_next;
  logic [REQ_W-1:0]  req_q, req_q_next;
  logic [CHAR_W-1:0] ch_q, ch_q_next;
  logic [LINK_W-1:0] n_hold, n_hold_next;
  logic              out_valid, out_valid_next;
  logic [ST_W-1:0]   out_status, out_status_next;
  logic [CHAR_W-1:0] out_char, out_char_next;
  logic              out_last, out_last_next;

  node_ctl_t         ctl;
  logic [AW-1:0]     rd_addr, char_waddr, prev_waddr, next_waddr;
  logic [CHAR_W-1:0] char_wdata, rd_char;
  logic [LINK_W-1:0] prev_wdata, next_wdata, rd_prev, rd_next;

  logic              p_ok, n_ok, free_ok, hold_ok, out_free, list_end;
  logic [CW:0]       count_inc;

  ctbl_node_store #(.NODES(NODES)) u_store (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .rd_addr    (rd_addr),
    .char_waddr (char_waddr),
    .char_wdata (char_wdata),
    .prev_waddr (prev_waddr),
    .prev_wdata (prev_wdata),
    .next_waddr (next_waddr),
    .next_wdata (next_wdata),
    .rd_char    (rd_char),
    .rd_prev    (rd_prev),
    .rd_next    (rd_next)
  );

  // link checks against the node count
  assign p_ok      = rd_prev < LINK_W'(NODES);
  assign n_ok      = rd_next < LINK_W'(NODES);
  assign hold_ok   = n_hold < LINK_W'(NODES);
  assign free_ok   = free_node < LINK_W'(NODES);
  assign out_free  = !out_valid || rsp.ready;
  assign count_inc = {1'b0, count} + (CW+1)'(1);
  assign list_end  = !(n_ok && count_inc < (CW+1)'(NODES - 1));

  assign req.ready    = (state == S_IDLE);
  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.char_out = out_char;
  assign rsp.last     = out_last;

  // sequencer next state and node store control
  always_comb begin
    state_next      = state;
    cursor_next     = cursor;
    free_node_next  = free_node;
    st_hold_next    = st_hold;
    count_next      = count;
    req_q_next      = req_q;
    ch_q_next       = ch_q;
    n_hold_next     = n_hold;
    out_valid_next  = out_valid && !rsp.ready;
    out_status_next = out_status;
    out_char_next   = out_char;
    out_last_next   = out_last;

    ctl        = '0;
    rd_addr    = cursor;
    char_waddr = free_node[AW-1:0];
    char_wdata = ch_q;
    prev_waddr = free_node[AW-1:0];
    prev_wdata = LINK_W'(cursor);
    next_waddr = free_node[AW-1:0];
    next_wdata = LINK_NULL;

    case (state)
      // take a request and fetch the links it needs
      S_IDLE: begin
        if (req.valid) begin
          req_q_next = req.req_type;
          ch_q_next  = req.char_in;
          ctl.rd_en  = 1'b1;
          rd_addr    = (req.req_type == REQ_LIST) ? AW'(0) : cursor;
          state_next = S_EDIT;
        end
      end

      // links of the cursor node (or head node for a listing) are here
      S_EDIT: begin
        state_next = S_REPLY;
        case (req_q)
          REQ_LEFT: begin
            if (p_ok) begin
              cursor_next  = rd_prev[AW-1:0];
              st_hold_next = ST_DONE;
            end else begin
              st_hold_next = ST_EDGE;
            end
          end
          REQ_RIGHT: begin
            if (n_ok) begin
              cursor_next  = rd_next[AW-1:0];
              st_hold_next = ST_DONE;
            end else begin
              st_hold_next = ST_EDGE;
            end
          end
          REQ_BACK: begin
            if (p_ok) begin
              ctl.wr_next = 1'b1;
              next_waddr  = rd_prev[AW-1:0];
              next_wdata  = n_ok ? rd_next : LINK_NULL;
              if (n_ok) begin
                ctl.wr_prev = 1'b1;
                prev_waddr  = rd_next[AW-1:0];
                prev_wdata  = rd_prev;
              end
              cursor_next  = rd_prev[AW-1:0];
              st_hold_next = ST_DONE;
            end else begin
              st_hold_next = ST_EDGE;
            end
          end
          REQ_INSERT: begin
            if (free_ok) begin
              // fill the fresh node first, relink neighbors next cycle
              ctl.wr_char = 1'b1;
              ctl.wr_prev = 1'b1;
              ctl.wr_next = 1'b1;
              next_wdata  = n_ok ? rd_next : LINK_NULL;
              n_hold_next = rd_next;
              state_next  = S_LINK;
            end else begin
              st_hold_next = ST_FULL;
            end
          end
          REQ_LIST: begin
            if (n_ok) begin
              ctl.rd_en  = 1'b1;
              rd_addr    = rd_next[AW-1:0];
              count_next = '0;
              state_next = S_LIST;
            end else begin
              st_hold_next = ST_EMPTY;
            end
          end
          default: begin
            st_hold_next = ST_EDGE;
          end
        endcase
      end

      // splice the fresh node between cursor and its old successor
      S_LINK: begin
        if (hold_ok) begin
          ctl.wr_prev = 1'b1;
          prev_waddr  = n_hold[AW-1:0];
          prev_wdata  = free_node;
        end
        ctl.wr_next    = 1'b1;
        next_waddr     = cursor;
        next_wdata     = free_node;
        cursor_next    = free_node[AW-1:0];
        free_node_next = free_node + LINK_W'(1);
        st_hold_next   = ST_DONE;
        state_next     = S_REPLY;
      end

      // one character beat per cycle while the output drains
      S_LIST: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_status_next = ST_CHAR;
          out_char_next   = rd_char;
          out_last_next   = list_end;
          if (list_end) begin
            state_next = S_IDLE;
          end else begin
            ctl.rd_en  = 1'b1;
            rd_addr    = rd_next[AW-1:0];
            count_next = count_inc[CW-1:0];
          end
        end
      end

      // single status beat
      S_REPLY: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_status_next = st_hold;
          out_char_next   = '0;
          out_last_next   = 1'b1;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cursor    <= '0;
      free_node <= LINK_W'(1);
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cursor    <= cursor_next;
      free_node <= free_node_next;
      out_valid <= out_valid_next;
    end
    st_hold    <= st_hold_next;
    count      <= count_next;
    req_q      <= req_q_next;
    ch_q       <= ch_q_next;
    n_hold     <= n_hold_next;
    out_status <= out_status_next;
    out_char   <= out_char_next;
    out_last   <= out_last_next;
  end

endmodule

>>> rtl/ctbl_node_store.sv
// node memories: characters, previous and next links, head link register
module ctbl_node_store #(
  parameter int NODES = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ctbl_pkg::node_ctl_t         ctl,
  input  logic [$clog2(NODES)-1:0]    rd_addr,
  input  logic [$clog2(NODES)-1:0]    char_waddr,
  input  logic [ctbl_pkg::CHAR_W-1:0] char_wdata,
  input  logic [$clog2(NODES)-1:0]    prev_waddr,
  input  logic [ctbl_pkg::LINK_W-1:0] prev_wdata,
  input  logic [$clog2(NODES)-1:0]    next_waddr,
  input  logic [ctbl_pkg::LINK_W-1:0] next_wdata,
  output logic [ctbl_pkg::CHAR_W-1:0] rd_char,
  output logic [ctbl_pkg::LINK_W-1:0] rd_prev,
  output logic [ctbl_pkg::LINK_W-1:0] rd_next
);
  import ctbl_pkg::*;

  localparam int AW = $clog2(NODES);

  logic [CHAR_W-1:0] char_mem [NODES];
  logic [LINK_W-1:0] prev_mem [NODES];
  logic [LINK_W-1:0] next_mem [NODES];
  logic [LINK_W-1:0] head_next;

  // head node link lives in a register so reset can clear it
  always_ff @(posedge clk) begin
    if (rst) begin
      head_next <= LINK_NULL;
    end else if (ctl.wr_next && next_waddr == AW'(0)) begin
      head_next <= next_wdata;
    end
  end

  // write ports
  always_ff @(posedge clk) begin
    if (ctl.wr_char) begin
      char_mem[char_waddr] <= char_wdata;
    end
    if (ctl.wr_prev) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (ctl.wr_next) begin
      next_mem[next_waddr] <= next_wdata;
    end
  end

  // registered read port, head node served from its register
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_char <= char_mem[rd_addr];
      if (rd_addr == AW'(0)) begin
        rd_prev <= LINK_NULL;
        rd_next <= head_next;
      end else begin
        rd_prev <= prev_mem[rd_addr];
        rd_next <= next_mem[rd_addr];
      end
    end
  end

endmodule

>>> bench/ctbl_checker.sv
// result checker of the cursor text buffer: tracks the list state, predicts and compares beats
module ctbl_checker #(
  parameter int NODES = 64
) (
  input  logic clk,
  input  logic rst,
  ctbl_req_if  req,
  ctbl_rsp_if  rsp,
  output int   errors,
  output int   pending,
  output int   beats_checked,
  output int   reqs_seen,
  output int   full_drops
);
  timeunit 1ns;
  timeprecision 1ps;
  import ctbl_pkg::*;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [CHAR_W-1:0] char_out;
    logic              last;
  } text_beat_t;

  // shadow copy of the node store, allocator and cursor
  logic [CHAR_W-1:0] node_char [NODES];
  logic [LINK_W-1:0] node_prev [NODES];
  logic [LINK_W-1:0] node_next [NODES];
  logic [LINK_W-1:0] alloc_ptr;
  logic [5:0]        cursor_pos;

  // beats still owed by the block, oldest first
  text_beat_t owed_beats [$];
  text_beat_t want_beat;
  text_beat_t got_beat;

  function automatic bit link_live(logic [LINK_W-1:0] link);
    return int'(link) < NODES;
  endfunction

  function automatic void owe(logic [ST_W-1:0] st, logic [CHAR_W-1:0] ch, logic lst);
    text_beat_t b;
    b.status   = st;
    b.char_out = ch;
    b.last     = lst;
    owed_beats.push_back(b);
  endfunction

  task automatic clear_text();
    for (int i = 0; i < NODES; i++) begin
      node_char[i] = '0;
      node_prev[i] = LINK_NULL;
      node_next[i] = LINK_NULL;
    end
    alloc_ptr  = 7'd1;
    cursor_pos = '0;
    owed_beats.delete();
  endtask

  // apply one edit request to the shadow list and queue the beats it owes
  task automatic apply_edit(logic [REQ_W-1:0] kind, logic [CHAR_W-1:0] ch);
    logic [LINK_W-1:0] cur;
    logic [LINK_W-1:0] p;
    logic [LINK_W-1:0] n;
    logic [LINK_W-1:0] fresh;
    logic [LINK_W-1:0] walk;
    logic [LINK_W-1:0] nxt;
    logic [ST_W-1:0]   st;
    int                count;
    cur = LINK_W'(int'(cursor_pos) % NODES);
    p   = node_prev[cur];
    n   = node_next[cur];
    st  = ST_EDGE;
    case (kind)
      REQ_LEFT: begin
        if (link_live(p)) begin
          cursor_pos = p[5:0];
          st = ST_DONE;
        end
      end
      REQ_RIGHT: begin
        if (link_live(n)) begin
          cursor_pos = n[5:0];
          st = ST_DONE;
        end
      end
      REQ_BACK: begin
        // unlink the cursor node, cursor falls back to its predecessor
        if (link_live(p)) begin
          node_next[p] = link_live(n) ? n : LINK_NULL;
          if (link_live(n)) node_prev[n] = p;
          cursor_pos = p[5:0];
          st = ST_DONE;
        end
      end
      REQ_INSERT: begin
        if (int'(alloc_ptr) >= NODES) begin
          st = ST_FULL;
          full_drops++;
        end else begin
          fresh = alloc_ptr;
          node_char[fresh] = ch;
          node_prev[fresh] = cur;
          node_next[fresh] = link_live(n) ? n : LINK_NULL;
          if (link_live(n)) node_prev[n] = fresh;
          node_next[cur] = fresh;
          cursor_pos = fresh[5:0];
          alloc_ptr = fresh + 7'd1;
          st = ST_DONE;
        end
      end
      REQ_LIST: begin
        // walk from the head, one beat per character
        count = 0;
        walk  = node_next[0];
        while (link_live(walk) && count < NODES - 1) begin
          nxt = node_next[walk];
          owe(ST_CHAR, node_char[walk], !link_live(nxt) || count == NODES - 2);
          count++;
          walk = nxt;
        end
        if (count == 0) owe(ST_EMPTY, '0, 1'b1);
      end
      default: st = ST_EDGE;
    endcase
    if (kind != REQ_LIST) owe(st, '0, 1'b1);
  endtask

  initial begin
    errors        = 0;
    pending       = 0;
    beats_checked = 0;
    reqs_seen     = 0;
    full_drops    = 0;
  end

  // watch both channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      clear_text();
    end else begin
      if (req.valid && req.ready) begin
        reqs_seen++;
        apply_edit(req.req_type, req.char_in);
      end
      if (rsp.valid && rsp.ready) begin
        got_beat.status   = rsp.status;
        got_beat.char_out = rsp.char_out;
        got_beat.last     = rsp.last;
        beats_checked++;
        if (owed_beats.size() == 0) begin
          errors++;
          $display("%0t unexpected beat: got status %0d char %h last %b",
                   $time, got_beat.status, got_beat.char_out, got_beat.last);
        end else begin
          want_beat = owed_beats.pop_front();
          if (got_beat.status !== want_beat.status ||
              got_beat.char_out !== want_beat.char_out ||
              got_beat.last !== want_beat.last) begin
            errors++;
            $display("%0t beat mismatch: expected status %0d char %h last %b, got status %0d char %h last %b",
                     $time, want_beat.status, want_beat.char_out, want_beat.last,
                     got_beat.status, got_beat.char_out, got_beat.last);
          end
        end
      end
    end
    pending = owed_beats.size();
  end

endmodule

>>> bench/testbench.sv
// top of the cursor text buffer bench: clock, reset, request stimulus and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ctbl_pkg::*;

  localparam int NODE_COUNT   = 64;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 38;
  localparam int TAIL_CYCLES  = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int errors;
  int pending;
  int beats_checked;
  int reqs_seen;
  int full_drops;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_trigger  = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int sent_items    = 0;

  ctbl_req_if req_ch ();
  ctbl_rsp_if rsp_ch ();

  cursor_text_buffer_linked_list_core #(
    .NODES(NODE_COUNT)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  ctbl_checker #(
    .NODES(NODE_COUNT)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .errors(errors),
    .pending(pending),
    .beats_checked(beats_checked),
    .reqs_seen(reqs_seen),
    .full_drops(full_drops)
  );

  always #6 clk = ~clk;

  // receiver: random back-pressure, plus a long hold-off on request
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_trigger != hold_seen) begin
        hold_seen = hold_trigger;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // offer one request beat, idling first at random, and return after it is taken
  task automatic send_req(logic [REQ_W-1:0] kind, logic [CHAR_W-1:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.char_in  <= ch;
    do @(posedge clk); while (!req_ch.ready);
    sent_items++;
    @(negedge clk);
  endtask

  // drop valid and hold off new requests until every owed beat has come back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // mostly typing and cursor work, with bursts of words and some bad codes
  task automatic random_edit();
    int pick;
    int burst;
    pick = $urandom_range(99);
    if (pick < 10) begin
      burst = $urandom_range(6, 2);
      repeat (burst) send_req(REQ_INSERT, 8'($urandom_range(255)));
      send_req(REQ_LIST, 8'($urandom_range(255)));
    end else if (pick < 42) begin
      send_req(REQ_INSERT, 8'($urandom_range(255)));
    end else if (pick < 54) begin
      send_req(REQ_LEFT, 8'($urandom_range(255)));
    end else if (pick < 66) begin
      send_req(REQ_RIGHT, 8'($urandom_range(255)));
    end else if (pick < 80) begin
      send_req(REQ_BACK, 8'($urandom_range(255)));
    end else if (pick < 94) begin
      send_req(REQ_LIST, 8'($urandom_range(255)));
    end else begin
      send_req(REQ_LIST + 3'($urandom_range(3, 1)), 8'($urandom_range(255)));
    end
  endtask

  // stimulus
  initial begin
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_LEFT;
    req_ch.char_in  = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty buffer, both ends, bad codes, typing and deleting
    send_idle_pct = 7;
    recv_idle_pct = 45;
    send_req(REQ_LIST, 8'h00);
    send_req(REQ_LEFT, 8'h00);
    send_req(REQ_RIGHT, 8'h00);
    send_req(REQ_BACK, 8'hFF);
    send_req(REQ_LIST + 3'd1, 8'h00);
    send_req(REQ_LIST + 3'd2, 8'hFF);
    send_req(REQ_LIST + 3'd3, 8'h00);
    send_req(REQ_INSERT, 8'h00);
    send_req(REQ_INSERT, 8'hFF);
    send_req(REQ_INSERT, 8'h41);
    send_req(REQ_LIST, 8'h00);
    send_req(REQ_RIGHT, 8'h00);
    repeat (4) send_req(REQ_LEFT, 8'h00);
    send_req(REQ_INSERT, 8'h5A);
    send_req(REQ_RIGHT, 8'h00);
    send_req(REQ_BACK, 8'h00);
    send_req(REQ_LIST, 8'h00);
    send_req(REQ_BACK, 8'h00);
    send_req(REQ_BACK, 8'h00);
    send_req(REQ_RIGHT, 8'h00);
    send_req(REQ_RIGHT, 8'h00);
    send_req(REQ_BACK, 8'h00);
    send_req(REQ_LIST, 8'h00);
    wait_drained();

    // long receiver hold-off while requests keep coming, so the input stalls
    hold_trigger++;
    send_req(REQ_LIST, 8'h00);
    send_req(REQ_INSERT, 8'h61);
    send_req(REQ_INSERT, 8'h62);
    send_req(REQ_LIST, 8'h00);
    send_req(REQ_LEFT, 8'h00);
    send_req(REQ_INSERT, 8'h63);
    send_req(REQ_LIST, 8'h00);
    wait_drained();

    // random phases: sender lightly idle, then receiver lightly idle, then no idling
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 45;
        end
        1: begin
          send_idle_pct = 45;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int done = sent_items; sent_items < done + PHASE_ITEMS; ) random_edit();
      if (phase == 1) wait_drained();
    end

    // a last insert and a full listing
    send_req(REQ_INSERT, 8'h7E);
    send_req(REQ_LIST, 8'h00);
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Run covered %0d requests and %0d result beats, %0d inserts dropped as full.",
             reqs_seen, beats_checked, full_drops);
    $display("Idle mixes on both sides and a %0d-cycle receiver hold-off were exercised.",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_400_000;
    $display("Timeout with %0d beats still owed", pending);
    $display("Regression FAIL");
    $finish;
  end

endmodule
